FILE: hdl/metaball_marching_squares_defines.svh
// assertion macros used by the checker file
`ifndef METABALL_MARCHING_SQUARES_DEFINES_SVH
`define METABALL_MARCHING_SQUARES_DEFINES_SVH

// clocked assertion, quiet while reset is low
`define MMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define MMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mms_pkg.sv
// shared constants, types and segment tables of the metaball contour block
`default_nettype none
package mms_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_CELL_WIDTH   = 2'd0;
    localparam logic [1:0] REG_CELL_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_ACTIVE_BALLS = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [3:0] CASE_EMPTY = 4'd0;
    localparam logic [3:0] CASE_FULL  = 4'd15;
    localparam logic [3:0] CASE_SADDLE_A = 4'd5;
    localparam logic [3:0] CASE_SADDLE_B = 4'd10;

    // cell edges whose midpoints a segment joins
    typedef enum logic [1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_BOTTOM = 2'd2,
        EDGE_LEFT   = 2'd3
    } t_edge;

    typedef struct packed {
        t_edge e0;
        t_edge e1;
    } t_seg;

    localparam int DIV_STEPS = 16;

    function automatic logic is_saddle(input logic [3:0] cs);
        return (cs == CASE_SADDLE_A) || (cs == CASE_SADDLE_B);
    endfunction

    // first segment of each case
    function automatic t_seg seg_first(input logic [3:0] cs);
        t_seg s;
        unique case (cs)
            4'd1, 4'd14: s = '{EDGE_LEFT, EDGE_BOTTOM};
            4'd2:        s = '{EDGE_BOTTOM, EDGE_RIGHT};
            4'd3, 4'd12: s = '{EDGE_LEFT, EDGE_RIGHT};
            4'd4, 4'd10, 4'd11: s = '{EDGE_TOP, EDGE_RIGHT};
            4'd5, 4'd7, 4'd8:   s = '{EDGE_TOP, EDGE_LEFT};
            4'd6, 4'd9:  s = '{EDGE_TOP, EDGE_BOTTOM};
            4'd13:       s = '{EDGE_RIGHT, EDGE_BOTTOM};
            default:     s = '{EDGE_TOP, EDGE_TOP};
        endcase
        return s;
    endfunction

    // second segment of the saddle cases
    function automatic t_seg seg_second(input logic [3:0] cs);
        return (cs == CASE_SADDLE_A) ? t_seg'{EDGE_RIGHT, EDGE_BOTTOM}
                                     : t_seg'{EDGE_LEFT, EDGE_BOTTOM};
    endfunction

endpackage
`default_nettype wire

FILE: hdl/mms_ram.sv
// generic single write, single read port ram with registered read
`default_nettype none
module mms_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [0:D-1];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: hdl/metaball_marching_squares.sv
// metaball field evaluator with marching-squares segment output
//
// A load (cmd 0) writes one ball into the table. An evaluate (cmd 1) reads active_balls
// balls (clamped to MAX_BALLS, and counted as one when zero) and holds busy from its transfer
// until its final result, the second one for the two saddle cases: one ball per cycle is
// read from the ball ram and fed through a pipeline that squares the distances and runs
// four 16-step restoring dividers, one per corner, one quotient bit per stage. Results come
// on o_valid for exactly one cycle each and cannot be stalled; o_last marks the final
// result of a cell and busy is low from that cycle on.
`default_nettype none
module metaball_marching_squares #(
    parameter int MAX_BALLS  = 16,
    parameter int COORD_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_cmd,
    input  wire logic [3:0]  i_ball_slot,
    input  wire logic [15:0] i_ball_pos_x,
    input  wire logic [15:0] i_ball_pos_y,
    input  wire logic [7:0]  i_ball_radius,
    input  wire logic [11:0] i_cell_x,
    input  wire logic [11:0] i_cell_y,
    output logic             o_valid,
    output logic [3:0]       o_case_index,
    output logic             o_has_segment,
    output logic [13:0]      o_seg_x0,
    output logic [13:0]      o_seg_y0,
    output logic [13:0]      o_seg_x1,
    output logic [13:0]      o_seg_y1,
    output logic             o_last
);
    localparam int AW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
    localparam int CW = $clog2(MAX_BALLS + 1);
    localparam logic [11:0] CMASK = 12'((64'd1 << COORD_BITS) - 64'd1);
    localparam int NS = mms_pkg::DIV_STEPS;
    localparam logic [16:0] ONE = 17'h10000;

    typedef struct packed {
        logic first;
        logic last;
        logic empty;
    } t_tok;

    // configuration
    logic [7:0] r_cell_w, r_cell_h;
    logic [4:0] r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_w <= 8'd6;
            r_cell_h <= 8'd6;
            r_active <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mms_pkg::REG_CELL_WIDTH:   r_cell_w <= i_cfg_data;
                mms_pkg::REG_CELL_HEIGHT:  r_cell_h <= i_cfg_data;
                mms_pkg::REG_ACTIVE_BALLS: r_active <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic r_busy;
    logic accept;
    assign accept = i_start && !r_busy;
    assign o_busy = r_busy;

    // ball table
    logic          ram_we;
    logic [39:0]   ram_rdata;
    logic [AW-1:0] idx_addr;
    assign ram_we = accept && (i_cmd == mms_pkg::CMD_LOAD)
                    && (32'(i_ball_slot) < MAX_BALLS);

    logic [CW-1:0] r_idx, r_n;
    logic          r_issuing;
    logic [11:0]   r_x, r_y;
    logic [CW-1:0] n_cnt;

    assign n_cnt = (32'(r_active) > MAX_BALLS) ? CW'(MAX_BALLS) : CW'(r_active);
    assign idx_addr = r_idx[AW-1:0];

    mms_ram #(.W(40), .D(MAX_BALLS)) u_ball_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_ball_slot)),
        .i_wdata ({i_ball_pos_x, i_ball_pos_y, i_ball_radius}),
        .i_raddr (idx_addr),
        .o_rdata (ram_rdata)
    );

    logic issue_last;
    assign issue_last = (r_n == '0) || (CW'(r_idx + 1'b1) == r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
        end else if (accept && (i_cmd == mms_pkg::CMD_EVAL)) begin
            r_issuing <= 1'b1;
        end else if (r_issuing && issue_last) begin
            r_issuing <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_cmd == mms_pkg::CMD_EVAL)) begin
            r_idx <= '0;
            r_n   <= n_cnt;
            r_x   <= i_cell_x & CMASK;
            r_y   <= i_cell_y & CMASK;
        end else if (r_issuing) begin
            r_idx <= CW'(r_idx + 1'b1);
        end
    end

    // corner coordinates in 13.4 pixels
    logic [16:0] cx_l, cx_r, cy_t, cy_b;
    assign cx_l = {1'b0, r_x, 4'b0};
    assign cx_r = {13'(r_x) + 13'(r_cell_w), 4'b0};
    assign cy_t = {1'b0, r_y, 4'b0};
    assign cy_b = {13'(r_y) + 13'(r_cell_h), 4'b0};

    // stage 1: ram read
    logic r_v1;
    t_tok r_t1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= r_issuing;
    end
    always_ff @(posedge i_clk) begin
        r_t1 <= '{first: (r_idx == '0), last: issue_last, empty: (r_n == '0)};
    end

    // stage 2: absolute differences
    logic        r_v2;
    t_tok        r_t2;
    logic [16:0] r_dx [0:1];
    logic [16:0] r_dy [0:1];
    logic [7:0]  r_rad2;
    logic [16:0] bx, by;
    assign bx = {1'b0, ram_rdata[39:24]};
    assign by = {1'b0, ram_rdata[23:8]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
    end
    always_ff @(posedge i_clk) begin
        r_t2     <= r_t1;
        r_rad2   <= ram_rdata[7:0];
        r_dx[0]  <= (cx_l >= bx) ? cx_l - bx : bx - cx_l;
        r_dx[1]  <= (cx_r >= bx) ? cx_r - bx : bx - cx_r;
        r_dy[0]  <= (cy_t >= by) ? cy_t - by : by - cy_t;
        r_dy[1]  <= (cy_b >= by) ? cy_b - by : by - cy_b;
    end

    // stage 3: squares
    logic        r_v3;
    t_tok        r_t3;
    logic [33:0] r_dxsq [0:1];
    logic [33:0] r_dysq [0:1];
    logic [15:0] r_rr3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
    end
    always_ff @(posedge i_clk) begin
        r_t3 <= r_t2;
        r_rr3 <= r_rad2 * r_rad2;
        for (int k = 0; k < 2; k++) begin
            r_dxsq[k] <= r_dx[k] * r_dx[k];
            r_dysq[k] <= r_dy[k] * r_dy[k];
        end
    end

    // stage 4: squared distance per corner (tl, tr, br, bl)
    logic        r_v4;
    t_tok        r_t4;
    logic [34:0] r_d2 [0:3];
    logic [15:0] r_rr4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= r_v3;
    end
    always_ff @(posedge i_clk) begin
        r_t4  <= r_t3;
        r_rr4 <= r_rr3;
        r_d2[0] <= 35'(r_dxsq[0]) + 35'(r_dysq[0]);
        r_d2[1] <= 35'(r_dxsq[1]) + 35'(r_dysq[0]);
        r_d2[2] <= 35'(r_dxsq[1]) + 35'(r_dysq[1]);
        r_d2[3] <= 35'(r_dxsq[0]) + 35'(r_dysq[1]);
    end

    // divider stages: index 0 loaded from stage 4, one quotient bit per stage
    logic        r_dv  [0:NS];
    t_tok        r_dt  [0:NS];
    logic [39:0] r_rem [0:NS][0:3];
    logic [49:0] r_dsh [0:NS][0:3];
    logic [15:0] r_q   [0:NS][0:3];
    logic        r_sat [0:NS][0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) r_dv[s] <= 1'b0;
        end else begin
            r_dv[0] <= r_v4;
            for (int s = 0; s < NS; s++) r_dv[s+1] <= r_dv[s];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dt[0] <= r_t4;
        for (int c = 0; c < 4; c++) begin
            // zero distance or quotient of at least one: term clamps to one
            r_sat[0][c] <= (r_d2[c] == '0) || ({r_rr4, 8'b0} >= 24'(r_d2[c]))
                           && (r_d2[c][34:24] == '0);
            r_rem[0][c] <= {r_rr4, 24'b0};
            r_dsh[0][c] <= {r_d2[c], 15'b0};
            r_q[0][c]   <= '0;
        end
        for (int s = 0; s < NS; s++) begin
            r_dt[s+1] <= r_dt[s];
            for (int c = 0; c < 4; c++) begin
                r_sat[s+1][c] <= r_sat[s][c];
                r_dsh[s+1][c] <= r_dsh[s][c] >> 1;
                if (50'(r_rem[s][c]) >= r_dsh[s][c]) begin
                    r_rem[s+1][c] <= 40'(50'(r_rem[s][c]) - r_dsh[s][c]);
                    r_q[s+1][c]   <= r_q[s][c] | (16'h8000 >> s);
                end else begin
                    r_rem[s+1][c] <= r_rem[s][c];
                    r_q[s+1][c]   <= r_q[s][c];
                end
            end
        end
    end

    // saturating field sums per corner
    logic [16:0] r_acc [0:3];
    logic [16:0] acc_n [0:3];
    logic [3:0]  corner_in;
    logic [16:0] term;
    logic [17:0] sum;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            term = r_dt[NS].empty ? 17'd0
                 : (r_sat[NS][c] ? ONE : {1'b0, r_q[NS][c]});
            sum  = 18'(r_dt[NS].first ? 17'd0 : r_acc[c]) + 18'(term);
            acc_n[c] = (sum >= 18'(ONE)) ? ONE : sum[16:0];
            corner_in[c] = acc_n[c][16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dv[NS]) begin
            for (int c = 0; c < 4; c++) r_acc[c] <= acc_n[c];
        end
    end

    logic       cell_done;
    logic [3:0] cs_n;
    assign cell_done = r_dv[NS] && r_dt[NS].last;
    assign cs_n = {corner_in[0], corner_in[1], corner_in[2], corner_in[3]};

    // segment emission
    logic        r_pend2;
    logic [3:0]  r_cs;
    logic        r_out_v, r_out_has, r_out_last;
    logic [3:0]  r_out_cs;
    logic [13:0] r_out_x0, r_out_y0, r_out_x1, r_out_y1;

    logic [13:0] x0, y0, xm, xr, ym, yb;
    assign x0 = {1'b0, r_x, 1'b0};
    assign y0 = {1'b0, r_y, 1'b0};
    assign xm = x0 + 14'(r_cell_w);
    assign xr = x0 + {5'b0, r_cell_w, 1'b0};
    assign ym = y0 + 14'(r_cell_h);
    assign yb = y0 + {5'b0, r_cell_h, 1'b0};

    function automatic logic [27:0] mid(input mms_pkg::t_edge e,
                                        input logic [13:0] ax0, input logic [13:0] axm,
                                        input logic [13:0] axr, input logic [13:0] ay0,
                                        input logic [13:0] aym, input logic [13:0] ayb);
        logic [27:0] p;
        unique case (e)
            mms_pkg::EDGE_TOP:    p = {axm, ay0};
            mms_pkg::EDGE_RIGHT:  p = {axr, aym};
            mms_pkg::EDGE_BOTTOM: p = {axm, ayb};
            default:              p = {ax0, aym};
        endcase
        return p;
    endfunction

    mms_pkg::t_seg seg_sel;
    logic [3:0]    cs_sel;
    logic [27:0]   p0, p1;
    assign cs_sel  = r_pend2 ? r_cs : cs_n;
    assign seg_sel = r_pend2 ? mms_pkg::seg_second(r_cs) : mms_pkg::seg_first(cs_n);
    assign p0 = mid(seg_sel.e0, x0, xm, xr, y0, ym, yb);
    assign p1 = mid(seg_sel.e1, x0, xm, xr, y0, ym, yb);

    logic emit, emit_last, no_line;
    assign emit      = r_pend2 || cell_done;
    assign no_line   = (cs_sel == mms_pkg::CASE_EMPTY) || (cs_sel == mms_pkg::CASE_FULL);
    assign emit_last = r_pend2 || !mms_pkg::is_saddle(cs_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pend2 <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= emit;
            r_pend2 <= cell_done && !r_pend2 && mms_pkg::is_saddle(cs_n);
            if (accept && (i_cmd == mms_pkg::CMD_EVAL)) begin
                r_busy <= 1'b1;
            end else if (emit && emit_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_done) r_cs <= cs_n;
        if (emit) begin
            r_out_cs   <= cs_sel;
            r_out_has  <= !no_line;
            r_out_last <= emit_last;
            r_out_x0   <= no_line ? 14'd0 : p0[27:14];
            r_out_y0   <= no_line ? 14'd0 : p0[13:0];
            r_out_x1   <= no_line ? 14'd0 : p1[27:14];
            r_out_y1   <= no_line ? 14'd0 : p1[13:0];
        end
    end

    assign o_valid       = r_out_v;
    assign o_case_index  = r_out_cs;
    assign o_has_segment = r_out_has;
    assign o_seg_x0      = r_out_x0;
    assign o_seg_y0      = r_out_y0;
    assign o_seg_x1      = r_out_x1;
    assign o_seg_y1      = r_out_y1;
    assign o_last        = r_out_last;
endmodule
`default_nettype wire

FILE: hdl/mms_checker.sv
// port-level checker for the metaball contour block and its bind
`default_nettype none
`include "metaball_marching_squares_defines.svh"
module mms_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_busy,
    input wire logic        o_valid,
    input wire logic [3:0]  o_case_index,
    input wire logic        o_has_segment,
    input wire logic        o_last
);
    // a non-final transfer means the cell is still in progress
    `MMS_ASSERT(a_mid_busy, !(o_valid && !o_last) || o_busy, "non-final result while idle")
    // the final transfer coincides with busy dropping
    `MMS_ASSERT(a_last_idle, !(o_valid && o_last) || !o_busy, "busy after final result")
    // empty results only for the all-out and all-in cases, always alone
    `MMS_ASSERT(a_empty, !(o_valid && !o_has_segment) || (o_last && (o_case_index == mms_pkg::CASE_EMPTY || o_case_index == mms_pkg::CASE_FULL)), "bad empty result")
    // a saddle's first segment is followed right away by its second
    `MMS_ASSERT_NEXT(a_pair, o_valid && !o_last, o_valid && o_last, "second saddle segment missing")
endmodule

bind metaball_marching_squares mms_checker u_mms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_busy        (o_busy),
    .o_valid       (o_valid),
    .o_case_index  (o_case_index),
    .o_has_segment (o_has_segment),
    .o_last        (o_last)
);
`default_nettype wire
